FILE: rtl/core/mvnb_pkg.sv
// ----------------------------------------------------------------------------
// mvnb_pkg
// Shared types and constants of the vertex normal builder: payload structs,
// command codes, shared-unit request/response and sequencer states.
// ----------------------------------------------------------------------------
package mvnb_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_FACES_DEF    = 2048;

    localparam int ALU_W = 67;
    localparam int OPB_W = 33;
    localparam int IT_W  = 6;
    localparam int SUM_W = 26;
    localparam int CNT_W = 12;

    localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [26:0]      ONE_Q14   = 27'd16384;

    localparam logic [IT_W-1:0] IT_MUL       = 6'd33;
    localparam logic [IT_W-1:0] IT_SQRT      = 6'd32;
    localparam logic [IT_W-1:0] IT_DIV_FACE  = 6'd15;
    localparam logic [IT_W-1:0] IT_DIV_QUERY = 6'd26;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FACE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ALU_MUL  = 2'd0,
        ALU_SQRT = 2'd1,
        ALU_DIV  = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [11:0]        face_count;
        logic [31:0]        radius;
    } t_out_item;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
        logic             neg;
        logic [ALU_W-1:0] opa;
        logic [OPB_W-1:0] opb;
        logic [OPB_W-1:0] opc;
        logic [IT_W-1:0]  iters;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] result;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_START,
        S_LD_WAIT,
        S_FC_RDA,
        S_FC_RDB,
        S_FC_RDC,
        S_FC_EDGE,
        S_X_START,
        S_X_WAIT,
        S_NORM,
        S_SQ_START,
        S_SQ_WAIT,
        S_RT_START,
        S_RT_WAIT,
        S_DV_START,
        S_DV_WAIT,
        S_AC_RD,
        S_AC_WR,
        S_Q_RD,
        S_Q_DV_START,
        S_Q_DV_WAIT,
        S_Q_RT_START,
        S_Q_RT_WAIT,
        S_Q_OUT
    } t_state;

endpackage

FILE: rtl/core/mesh_vertex_normal_builder_top.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_builder_top
// Per-vertex averaged lighting normals for a triangle mesh, built by a small
// sequencer around one shared multiply / square root / divide unit.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// Throughput: one item at a time, paced by the shared unit. A load runs three
// squares; a face runs six cross terms, the normalize shifts, three squares, a
// root, three divides and three read-modify-writes; a query runs up to three
// divides and a root. Reset: sweep every entry of the normal/count memory with
// the input stalled. Stalls: hold only when a second result is ready early.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_builder_top import mvnb_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_FACES    = MAX_FACES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FW = $clog2(MAX_FACES + 1);

    // ---- state ----
    t_state r_state, n_state;
    t_in_item r_item;
    logic [2:0]  r_j;
    logic [ALU_W-1:0] r_p;
    logic [63:0] r_max;
    logic [FW-1:0] r_faces;
    logic [AW-1:0] r_clr;
    logic [95:0] r_pa;
    logic signed [32:0] r_e1 [3];
    logic signed [32:0] r_e2 [3];
    logic [65:0] r_m [3];
    logic        r_neg [3];
    logic [31:0] r_r;
    logic signed [15:0] r_n [3];
    logic        r_oor;
    logic        r_out_valid;
    t_out_item   r_out;

    // ---- memories ----
    logic [95:0] r_vtx_mem [MAX_VERTICES];
    logic [89:0] r_acc_mem [MAX_VERTICES];
    logic [95:0] r_vrd;
    logic [89:0] r_ard;

    logic        vtx_we, vtx_re;
    logic [AW-1:0] vtx_waddr, vtx_raddr;
    logic [95:0] vtx_wdata;
    logic        acc_we, acc_re;
    logic [AW-1:0] acc_addr;
    logic [89:0] acc_wdata;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    logic in_acc, out_fire;
    logic idx_in_ok, face_ok;
    logic [65:0] or_all;
    logic [89:0] q_entry;
    logic [11:0] q_cnt;
    logic signed [25:0] q_s;
    logic [25:0] q_mg;
    logic [26:0] q_num;
    logic [45:0] f_num;
    logic signed [32:0] x_op, y_op;
    logic        x_minus;
    logic [66:0] x_mag;
    logic [11:0] a_cnt;

    function automatic logic idx_ok(logic [9:0] v);
        return 32'(v) < MAX_VERTICES;
    endfunction

    function automatic logic [32:0] mag33(logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic signed [15:0] to_q14(logic [26:0] mg, logic neg);
        logic [15:0] m;
        m = (mg > ONE_Q14) ? 16'(ONE_Q14) : mg[15:0];
        return neg ? 16'(-m) : m;
    endfunction

    function automatic logic [25:0] sat_add(logic [25:0] s, logic signed [15:0] n);
        logic signed [26:0] t;
        t = $signed({s[25], s}) + $signed({{11{n[15]}}, n});
        if (t > 27'sd33554431) begin
            return 26'h1FFFFFF;
        end else if (t < -27'sd33554432) begin
            return 26'h2000000;
        end
        return t[25:0];
    endfunction

    function automatic logic signed [32:0] pos_sel(t_in_item it, logic [2:0] j);
        logic signed [32:0] v;
        unique case (j)
            3'd0:    v = {it.pos_x[31], it.pos_x};
            3'd1:    v = {it.pos_y[31], it.pos_y};
            default: v = {it.pos_z[31], it.pos_z};
        endcase
        return v;
    endfunction

    mvnb_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_fire    = (r_state == S_Q_OUT) && (!r_out_valid || !i_out_stall);

    assign idx_in_ok = idx_ok(i_in_data.vertex_index);
    assign face_ok   = idx_ok(i_in_data.corner_a) && idx_ok(i_in_data.corner_b)
                    && idx_ok(i_in_data.corner_c) && (r_faces < FW'(MAX_FACES));

    assign or_all  = r_m[0] | r_m[1] | r_m[2];
    assign q_entry = r_oor ? '0 : r_ard;
    assign q_cnt   = q_entry[89:78];
    assign a_cnt   = r_ard[89:78];

    // ---- datapath selections ----
    always_comb begin
        unique case (r_j)
            3'd0:    q_s = q_entry[25:0];
            3'd1:    q_s = q_entry[51:26];
            default: q_s = q_entry[77:52];
        endcase
        q_mg  = q_s[25] ? 26'(-q_s) : 26'(q_s);
        q_num = {1'b0, q_mg} + {16'b0, q_cnt[11:1]};
        f_num = {r_m[r_j[1:0]][30:0], 14'b0} + {15'b0, r_r[31:1]};

        // cross product terms: c0 = e1y*e2z - e1z*e2y, and rotate
        unique case (r_j)
            3'd0:    begin x_op = r_e1[1]; y_op = r_e2[2]; x_minus = 1'b0; end
            3'd1:    begin x_op = r_e1[2]; y_op = r_e2[1]; x_minus = 1'b1; end
            3'd2:    begin x_op = r_e1[2]; y_op = r_e2[0]; x_minus = 1'b0; end
            3'd3:    begin x_op = r_e1[0]; y_op = r_e2[2]; x_minus = 1'b1; end
            3'd4:    begin x_op = r_e1[0]; y_op = r_e2[1]; x_minus = 1'b0; end
            default: begin x_op = r_e1[1]; y_op = r_e2[0]; x_minus = 1'b1; end
        endcase
        x_mag = alu_rsp.result[ALU_W-1] ? 67'(-alu_rsp.result) : alu_rsp.result;
    end

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == AW'(MAX_VERTICES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.cmd)
                        CMD_LOAD:  n_state = idx_in_ok ? S_LD_START : S_IDLE;
                        CMD_FACE:  n_state = face_ok ? S_FC_RDA : S_IDLE;
                        CMD_QUERY: n_state = S_Q_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_START: n_state = S_LD_WAIT;
            S_LD_WAIT:  if (alu_rsp.done) n_state = (r_j == 3'd2) ? S_IDLE : S_LD_START;
            S_FC_RDA:   n_state = S_FC_RDB;
            S_FC_RDB:   n_state = S_FC_RDC;
            S_FC_RDC:   n_state = S_FC_EDGE;
            S_FC_EDGE:  n_state = S_X_START;
            S_X_START:  n_state = S_X_WAIT;
            S_X_WAIT:   if (alu_rsp.done) n_state = (r_j == 3'd5) ? S_NORM : S_X_START;
            S_NORM: begin
                if (or_all == '0) begin
                    n_state = S_AC_RD;
                end else if (!(|or_all[65:31]) && or_all[30]) begin
                    n_state = S_SQ_START;
                end
            end
            S_SQ_START: n_state = S_SQ_WAIT;
            S_SQ_WAIT:  if (alu_rsp.done) n_state = (r_j == 3'd2) ? S_RT_START : S_SQ_START;
            S_RT_START: n_state = S_RT_WAIT;
            S_RT_WAIT:  if (alu_rsp.done) n_state = S_DV_START;
            S_DV_START: n_state = S_DV_WAIT;
            S_DV_WAIT:  if (alu_rsp.done) n_state = (r_j == 3'd2) ? S_AC_RD : S_DV_START;
            S_AC_RD:    n_state = S_AC_WR;
            S_AC_WR:    n_state = (r_j == 3'd2) ? S_IDLE : S_AC_RD;
            S_Q_RD:     n_state = S_Q_DV_START;
            S_Q_DV_START: begin
                if (q_cnt > 12'd1) begin
                    n_state = S_Q_DV_WAIT;
                end else if (r_j == 3'd2) begin
                    n_state = S_Q_RT_START;
                end
            end
            S_Q_DV_WAIT:  if (alu_rsp.done) n_state = (r_j == 3'd2) ? S_Q_RT_START : S_Q_DV_START;
            S_Q_RT_START: n_state = S_Q_RT_WAIT;
            S_Q_RT_WAIT:  if (alu_rsp.done) n_state = S_Q_OUT;
            S_Q_OUT:      if (out_fire) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // ---- control outputs: shared unit requests and memory ports ----
    always_comb begin
        alu_req   = '0;
        vtx_we    = 1'b0;
        vtx_re    = 1'b0;
        vtx_waddr = AW'(i_in_data.vertex_index);
        vtx_raddr = AW'(r_item.corner_a);
        vtx_wdata = {i_in_data.pos_z, i_in_data.pos_y, i_in_data.pos_x};
        acc_we    = 1'b0;
        acc_re    = 1'b0;
        acc_addr  = r_clr;
        acc_wdata = '0;
        unique case (r_state)
            S_CLEAR: acc_we = 1'b1;
            S_IDLE: begin
                // load: store the point, clear its sums and count
                if (in_acc && (i_in_data.cmd == CMD_LOAD) && idx_in_ok) begin
                    vtx_we   = 1'b1;
                    acc_we   = 1'b1;
                    acc_addr = AW'(i_in_data.vertex_index);
                end
            end
            S_LD_START: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.opa   = (r_j == 3'd0) ? '0 : r_p;
                alu_req.opb   = mag33(pos_sel(r_item, r_j));
                alu_req.opc   = mag33(pos_sel(r_item, r_j));
                alu_req.iters = IT_MUL;
            end
            S_FC_RDA: begin
                vtx_re    = 1'b1;
                vtx_raddr = AW'(r_item.corner_a);
            end
            S_FC_RDB: begin
                vtx_re    = 1'b1;
                vtx_raddr = AW'(r_item.corner_b);
            end
            S_FC_RDC: begin
                vtx_re    = 1'b1;
                vtx_raddr = AW'(r_item.corner_c);
            end
            S_X_START: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.neg   = x_op[32] ^ y_op[32] ^ x_minus;
                alu_req.opa   = r_j[0] ? r_p : '0;
                alu_req.opb   = mag33(x_op);
                alu_req.opc   = mag33(y_op);
                alu_req.iters = IT_MUL;
            end
            S_SQ_START: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.opa   = (r_j == 3'd0) ? '0 : r_p;
                alu_req.opb   = r_m[r_j[1:0]][32:0];
                alu_req.opc   = r_m[r_j[1:0]][32:0];
                alu_req.iters = IT_MUL;
            end
            S_RT_START: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_req.opa   = {3'b0, r_p[63:0]};
                alu_req.iters = IT_SQRT;
            end
            S_DV_START: begin
                // quotient stays below 2^15, so the top numerator bits seed
                // the remainder
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.opa   = {4'b0, f_num[45:15], f_num[14:0], 17'b0};
                alu_req.opb   = {1'b0, r_r};
                alu_req.iters = IT_DIV_FACE;
            end
            S_AC_RD: begin
                acc_re = 1'b1;
                unique case (r_j)
                    3'd0:    acc_addr = AW'(r_item.corner_a);
                    3'd1:    acc_addr = AW'(r_item.corner_b);
                    default: acc_addr = AW'(r_item.corner_c);
                endcase
            end
            S_AC_WR: begin
                unique case (r_j)
                    3'd0:    acc_addr = AW'(r_item.corner_a);
                    3'd1:    acc_addr = AW'(r_item.corner_b);
                    default: acc_addr = AW'(r_item.corner_c);
                endcase
                // a saturated count drops further faces
                acc_we    = (a_cnt != COUNT_MAX);
                acc_wdata = {a_cnt + 12'd1,
                             sat_add(r_ard[77:52], r_n[2]),
                             sat_add(r_ard[51:26], r_n[1]),
                             sat_add(r_ard[25:0],  r_n[0])};
            end
            S_Q_RD: begin
                acc_re   = !r_oor;
                acc_addr = AW'(r_item.vertex_index);
            end
            S_Q_DV_START: begin
                alu_req.start = (q_cnt > 12'd1);
                alu_req.op    = ALU_DIV;
                alu_req.opa   = {35'b0, q_num[25:0], 6'b0};
                alu_req.opb   = 33'(q_cnt);
                alu_req.iters = IT_DIV_QUERY;
            end
            S_Q_RT_START: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_SQRT;
                alu_req.opa   = {3'b0, r_max};
                alu_req.iters = IT_SQRT;
            end
            default: ;
        endcase
    end

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (vtx_we) begin
            r_vtx_mem[vtx_waddr] <= vtx_wdata;
        end
        if (vtx_re) begin
            r_vrd <= r_vtx_mem[vtx_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc_mem[acc_addr] <= acc_wdata;
        end
        if (acc_re) begin
            r_ard <= r_acc_mem[acc_addr];
        end
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_j         <= '0;
            r_max       <= '0;
            r_faces     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_j <= '0;
                    if (in_acc && (i_in_data.cmd == CMD_FACE) && face_ok) begin
                        r_faces <= r_faces + 1'b1;
                    end
                end
                S_LD_WAIT: begin
                    if (alu_rsp.done) begin
                        r_j <= r_j + 3'd1;
                        // raise the running maximum of the squared distance
                        if ((r_j == 3'd2) && (alu_rsp.result[63:0] > r_max)) begin
                            r_max <= alu_rsp.result[63:0];
                        end
                    end
                end
                S_FC_EDGE: r_j <= '0;
                S_X_WAIT:  if (alu_rsp.done) r_j <= (r_j == 3'd5) ? 3'd0 : r_j + 3'd1;
                S_SQ_WAIT: if (alu_rsp.done) r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                S_DV_WAIT: if (alu_rsp.done) r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                S_AC_WR:   r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                S_Q_DV_START: begin
                    if (q_cnt <= 12'd1) begin
                        r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                    end
                end
                S_Q_DV_WAIT: if (alu_rsp.done) r_j <= (r_j == 3'd2) ? 3'd0 : r_j + 3'd1;
                default: ;
            endcase
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_item <= i_in_data;
                    r_oor  <= !idx_in_ok;
                end
            end
            S_LD_WAIT:  if (alu_rsp.done) r_p <= alu_rsp.result;
            S_FC_RDB:   r_pa <= r_vrd;
            S_FC_RDC: begin
                for (int i = 0; i < 3; i++) begin
                    r_e2[i] <= $signed({r_vrd[32*i+31], r_vrd[32*i +: 32]})
                             - $signed({r_pa[32*i+31], r_pa[32*i +: 32]});
                end
            end
            S_FC_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= $signed({r_vrd[32*i+31], r_vrd[32*i +: 32]})
                             - $signed({r_pa[32*i+31], r_pa[32*i +: 32]});
                end
            end
            S_X_WAIT: begin
                if (alu_rsp.done) begin
                    r_p <= alu_rsp.result;
                    if (r_j[0]) begin
                        r_m[r_j[2:1]]   <= x_mag[65:0];
                        r_neg[r_j[2:1]] <= alu_rsp.result[ALU_W-1];
                    end
                end
            end
            S_NORM: begin
                if (or_all == '0) begin
                    // degenerate face: add a zero normal
                    for (int i = 0; i < 3; i++) begin
                        r_n[i] <= '0;
                    end
                end else if (|or_all[65:31]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] >> 1;
                    end
                end else if (!or_all[30]) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            S_SQ_WAIT:   if (alu_rsp.done) r_p <= alu_rsp.result;
            S_RT_WAIT:   if (alu_rsp.done) r_r <= alu_rsp.result[31:0];
            S_DV_WAIT: begin
                if (alu_rsp.done) begin
                    r_n[r_j[1:0]] <= to_q14({12'b0, alu_rsp.result[14:0]}, r_neg[r_j[1:0]]);
                end
            end
            S_Q_DV_START: begin
                if (q_cnt <= 12'd1) begin
                    r_n[r_j[1:0]] <= to_q14({1'b0, q_mg}, q_s[25]);
                end
            end
            S_Q_DV_WAIT: begin
                if (alu_rsp.done) begin
                    r_n[r_j[1:0]] <= to_q14({1'b0, alu_rsp.result[25:0]}, q_s[25]);
                end
            end
            S_Q_RT_WAIT: if (alu_rsp.done) r_r <= alu_rsp.result[31:0];
            S_Q_OUT: begin
                if (out_fire) begin
                    r_out.norm_x     <= r_n[0];
                    r_out.norm_y     <= r_n[1];
                    r_out.norm_z     <= r_n[2];
                    r_out.face_count <= q_cnt;
                    r_out.radius     <= r_r;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/mvnb_alu.sv
// ----------------------------------------------------------------------------
// mvnb_alu
// Shared iterative unit: shift-add multiply-accumulate, bitwise square root
// and restoring division, one step per cycle on a single wide adder.
// ----------------------------------------------------------------------------
module mvnb_alu import mvnb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] r_a, r_b, r_c;
    logic [ALU_W-1:0] n_a, n_b, n_c;
    logic [IT_W-1:0]  r_cnt;
    t_alu_op          r_op;
    logic             r_neg;
    logic             r_busy;
    logic             r_done;

    logic [ALU_W-1:0] add_a, add_b, tr;
    logic             add_sub;
    logic [ALU_W:0]   sum;
    logic             ge;

    always_comb begin
        tr      = {r_a[ALU_W-2:0], r_c[31]};
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        unique case (r_op)
            ALU_MUL: begin
                add_a   = r_a;
                add_b   = r_b;
                add_sub = r_neg;
            end
            ALU_SQRT: begin
                add_a   = r_a;
                add_b   = r_c | r_b;
                add_sub = 1'b1;
            end
            ALU_DIV: begin
                add_a   = tr;
                add_b   = r_b;
                add_sub = 1'b1;
            end
            default: ;
        endcase
        sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
            + (ALU_W+1)'(add_sub);
        ge  = ~sum[ALU_W];

        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        unique case (r_op)
            ALU_MUL: begin
                if (r_c[0]) begin
                    n_a = sum[ALU_W-1:0];
                end
                n_b = r_b << 1;
                n_c = r_c >> 1;
            end
            ALU_SQRT: begin
                if (ge) begin
                    n_a = sum[ALU_W-1:0];
                    n_c = (r_c >> 1) | r_b;
                end else begin
                    n_c = r_c >> 1;
                end
                n_b = r_b >> 2;
            end
            ALU_DIV: begin
                n_a = ge ? sum[ALU_W-1:0] : tr;
                n_c = {r_c[ALU_W-2:0], ge};
            end
            default: ;
        endcase
    end

    // control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
            r_neg  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
                r_op   <= i_req.op;
                r_neg  <= i_req.neg;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands: load on start, step while busy
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            unique case (i_req.op)
                ALU_MUL: begin
                    r_a <= i_req.opa;
                    r_b <= ALU_W'(i_req.opb);
                    r_c <= ALU_W'(i_req.opc);
                end
                ALU_SQRT: begin
                    r_a <= i_req.opa;
                    r_b <= ALU_W'(1) << 62;
                    r_c <= '0;
                end
                ALU_DIV: begin
                    r_a <= ALU_W'(i_req.opa >> 32);
                    r_b <= ALU_W'(i_req.opb);
                    r_c <= ALU_W'(i_req.opa[31:0]);
                end
                default: ;
            endcase
        end else if (r_busy) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == ALU_MUL) ? r_a : r_c;

endmodule
